// ----- rtl/lgtc_pkg.sv -----
// ----------------------------------------------------------------------------
// lgtc_pkg
// Types and constants shared by the glyph tile cache modules.
// ----------------------------------------------------------------------------
package lgtc_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    localparam logic [7:0] NONE_MARK  = 8'hFF;
    localparam logic [7:0] CHAR_BASE  = 8'h20;
    localparam logic [9:0] GLYPH_BASE = 10'd32;
    localparam logic [9:0] GLYPH_HALF = 10'd16;

    localparam logic [1:0] MODE_BANK0 = 2'd0;
    localparam logic [1:0] MODE_BANK1 = 2'd1;
    localparam logic [1:0] MODE_ALT   = 2'd2;
    // unassigned placement code, behaves as bank zero
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    localparam logic [1:0] REG_TILE_BASE = 2'd0;
    localparam logic [1:0] REG_LAST_TILE = 2'd1;
    localparam logic [1:0] REG_PLACEMENT = 2'd2;
    localparam logic [1:0] REG_COLOR_HW  = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [7:0] font_id;
    } t_in_item;

    typedef struct packed {
        logic [5:0] entry;
        logic [7:0] tile;
        logic       bank;
        logic       hit;
        logic [9:0] glyph_top_index;
        logic [9:0] glyph_bottom_index;
    } t_out_item;

    typedef struct packed {
        logic [7:0] tile_base;
        logic [7:0] last_tile;
        logic [1:0] placement;
        logic       color_hardware;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic clear;
        logic set_cur;
        logic rd_cur;
        logic rd_idx;
        logic step;
        logic take_hit;
        logic alloc;
        logic unlink_hit;
        logic unlink_evict;
        logic push_a;
        logic push_b;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_flush;
        logic need_clear;
        logic cur_done;
        logic key_match;
        logic cur_is_newest;
        logic can_fill;
        logic out_busy;
    } t_sts;

endpackage

// ----- rtl/lgtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lgtc_ctrl
// Sequencer for lookup, flush, relink, fill/evict and result hand-off.
// ----------------------------------------------------------------------------
module lgtc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lgtc_pkg::t_sts i_sts,
    output lgtc_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_CMP, S_MISS, S_EV_RD, S_EV_UNLINK,
        S_UNLINK_HIT, S_PUSH_A, S_PUSH_B, S_EMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_flush) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.clear   = i_sts.need_clear;
                    o_cmd.set_cur = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.cur_done) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.key_match) begin
                    o_cmd.take_hit = 1'b1;
                    n_state = i_sts.cur_is_newest ? S_EMIT : S_UNLINK_HIT;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_MISS: begin
                o_cmd.alloc = 1'b1;
                n_state = i_sts.can_fill ? S_PUSH_A : S_EV_RD;
            end
            S_EV_RD: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_EV_UNLINK;
            end
            S_EV_UNLINK: begin
                o_cmd.unlink_evict = 1'b1;
                n_state            = S_PUSH_A;
            end
            S_UNLINK_HIT: begin
                o_cmd.unlink_hit = 1'b1;
                n_state          = S_PUSH_A;
            end
            S_PUSH_A: begin
                o_cmd.push_a = 1'b1;
                n_state      = S_PUSH_B;
            end
            S_PUSH_B: begin
                o_cmd.push_b = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/lgtc_dp.sv -----
// ----------------------------------------------------------------------------
// lgtc_dp
// Key and link memories, list pointers, clear logic and result register.
// ----------------------------------------------------------------------------
module lgtc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lgtc_pkg::t_cmd      i_cmd,
    input  lgtc_pkg::t_cfg      i_cfg,
    input  lgtc_pkg::t_in_item  i_item,
    input  logic                i_out_stall,
    output lgtc_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output lgtc_pkg::t_out_item o_out_item
);

    localparam int IW = lgtc_pkg::IDX_W;
    localparam int CW = lgtc_pkg::CNT_W;

    logic [7:0] key_mem   [lgtc_pkg::ENTRIES];
    logic [7:0] older_mem [lgtc_pkg::ENTRIES];
    logic [7:0] newer_mem [lgtc_pkg::ENTRIES];

    lgtc_pkg::t_in_item  r_item;
    lgtc_pkg::t_out_item r_out;
    logic          r_out_valid;
    logic [7:0]    r_rd_key, r_rd_older, r_rd_newer;
    logic [7:0]    r_newest, r_oldest, r_cur, r_idx;
    logic [CW-1:0] r_used, r_usable, r_steps;
    logic [1:0]    r_mode;
    logic [7:0]    r_font;
    logic          r_ready, r_hit;

    function automatic logic ptr_ok(input logic [7:0] p);
        return p < 8'(lgtc_pkg::ENTRIES);
    endfunction

    // clear-time sizing
    logic [1:0] clr_mode;
    logic [7:0] clr_range, clr_n;
    logic [CW-1:0] clr_usable;
    always_comb begin
        clr_mode  = i_cfg.color_hardware ? i_cfg.placement : lgtc_pkg::MODE_BANK0;
        clr_range = i_cfg.last_tile - i_cfg.tile_base + 8'd1;
        clr_n     = (clr_mode == lgtc_pkg::MODE_ALT) ? {clr_range[7:1], 1'b0}
                                                      : {1'b0, clr_range[7:1]};
        if (i_cfg.last_tile < i_cfg.tile_base || clr_n == 8'd0
                || clr_n > 8'(lgtc_pkg::ENTRIES))
            clr_usable = CW'(lgtc_pkg::ENTRIES);
        else
            clr_usable = CW'(clr_n);
    end

    // memory write ports
    logic          key_we, older_we, newer_we;
    logic [IW-1:0] key_wa, older_wa, newer_wa, rd_a;
    logic [7:0]    older_wd, newer_wd;
    always_comb begin
        key_we   = i_cmd.push_a && !r_hit;
        key_wa   = r_idx[IW-1:0];
        older_we = 1'b0;
        older_wa = r_idx[IW-1:0];
        older_wd = r_newest;
        newer_we = 1'b0;
        newer_wa = r_idx[IW-1:0];
        newer_wd = lgtc_pkg::NONE_MARK;
        if (i_cmd.unlink_hit) begin
            older_we = ptr_ok(r_rd_newer);
            older_wa = r_rd_newer[IW-1:0];
            older_wd = r_rd_older;
            newer_we = ptr_ok(r_rd_older);
            newer_wa = r_rd_older[IW-1:0];
            newer_wd = r_rd_newer;
        end else if (i_cmd.unlink_evict) begin
            older_we = ptr_ok(r_rd_newer);
            older_wa = r_rd_newer[IW-1:0];
            older_wd = lgtc_pkg::NONE_MARK;
        end else if (i_cmd.push_a) begin
            older_we = 1'b1;
            newer_we = 1'b1;
        end else if (i_cmd.push_b) begin
            newer_we = ptr_ok(r_newest);
            newer_wa = r_newest[IW-1:0];
            newer_wd = r_idx;
        end
        rd_a = i_cmd.rd_idx ? r_idx[IW-1:0] : r_cur[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (key_we)   key_mem[key_wa]     <= r_item.char_code;
        if (older_we) older_mem[older_wa] <= older_wd;
        if (newer_we) newer_mem[newer_wa] <= newer_wd;
        if (i_cmd.rd_cur || i_cmd.rd_idx) begin
            r_rd_key   <= key_mem[rd_a];
            r_rd_older <= older_mem[rd_a];
            r_rd_newer <= newer_mem[rd_a];
        end
    end

    // result fields
    logic [7:0] tile, gn;
    logic       bank;
    logic [9:0] gtop;
    always_comb begin
        if (r_mode == lgtc_pkg::MODE_ALT)
            tile = i_cfg.tile_base + {r_idx[7:1], 1'b0};
        else
            tile = i_cfg.tile_base + {r_idx[6:0], 1'b0};
        case (r_mode)
            lgtc_pkg::MODE_BANK1: bank = 1'b1;
            lgtc_pkg::MODE_ALT:   bank = r_idx[0];
            default:              bank = 1'b0;
        endcase
        gn   = r_item.char_code - lgtc_pkg::CHAR_BASE;
        gtop = lgtc_pkg::GLYPH_BASE + {1'b0, gn[7:4], 5'b0} + {6'b0, gn[3:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_item <= i_item;
        if (i_cmd.emit) begin
            r_out.entry              <= r_idx[5:0];
            r_out.tile               <= tile;
            r_out.bank               <= bank;
            r_out.hit                <= r_hit;
            r_out.glyph_top_index    <= gtop;
            r_out.glyph_bottom_index <= gtop + lgtc_pkg::GLYPH_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_newest    <= lgtc_pkg::NONE_MARK;
            r_oldest    <= lgtc_pkg::NONE_MARK;
            r_cur       <= lgtc_pkg::NONE_MARK;
            r_idx       <= '0;
            r_used      <= '0;
            r_usable    <= CW'(lgtc_pkg::ENTRIES);
            r_steps     <= '0;
            r_mode      <= lgtc_pkg::MODE_BANK0;
            r_font      <= '0;
            r_ready     <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            if (i_cmd.emit)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
            if (i_cmd.clear) begin
                r_mode   <= clr_mode;
                r_usable <= clr_usable;
                r_used   <= '0;
                r_newest <= lgtc_pkg::NONE_MARK;
                r_oldest <= lgtc_pkg::NONE_MARK;
                r_font   <= r_item.font_id;
                r_ready  <= 1'b1;
            end
            if (i_cmd.set_cur) begin
                r_cur   <= i_cmd.clear ? lgtc_pkg::NONE_MARK : r_newest;
                r_steps <= '0;
                r_hit   <= 1'b0;
            end
            if (i_cmd.step) begin
                r_cur   <= r_rd_older;
                r_steps <= r_steps + CW'(1);
            end
            if (i_cmd.take_hit) begin
                r_idx <= r_cur;
                r_hit <= 1'b1;
            end
            if (i_cmd.alloc) begin
                if (r_used < r_usable) begin
                    r_idx  <= 8'(r_used);
                    r_used <= r_used + CW'(1);
                end else begin
                    r_idx <= ptr_ok(r_oldest) ? r_oldest : 8'd0;
                end
            end
            if (i_cmd.unlink_hit && !ptr_ok(r_rd_older))
                r_oldest <= r_rd_newer;
            if (i_cmd.unlink_evict) begin
                if (ptr_ok(r_rd_newer)) begin
                    r_oldest <= r_rd_newer;
                end else begin
                    r_newest <= lgtc_pkg::NONE_MARK;
                    r_oldest <= lgtc_pkg::NONE_MARK;
                end
            end
            if (i_cmd.push_b) begin
                r_newest <= r_idx;
                if (!ptr_ok(r_oldest)) r_oldest <= r_idx;
            end
        end
    end

    always_comb begin
        o_sts.is_flush      = (r_item.kind == lgtc_pkg::KIND_FLUSH);
        o_sts.need_clear    = !r_ready || (r_item.font_id != r_font);
        o_sts.cur_done      = !ptr_ok(r_cur) || (r_steps == CW'(lgtc_pkg::ENTRIES));
        o_sts.key_match     = (r_rd_key == r_item.char_code);
        o_sts.cur_is_newest = (r_cur == r_newest);
        o_sts.can_fill      = (r_used < r_usable);
        o_sts.out_busy      = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/lru_glyph_tile_cache.sv -----
// ----------------------------------------------------------------------------
// lru_glyph_tile_cache
// Fully associative LRU cache mapping character codes to glyph tile pairs.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one item per beat: a lookup
// of a character under a font, or a flush. A lookup returns one beat on the
// output channel (o_out_valid / i_out_stall); a flush returns none.
// Items are handled one at a time. A lookup walks the recency list from the
// newest entry, at most 64 of them, one memory read and one compare each,
// then relinks a hit not already newest, or on a miss fills a free entry or
// evicts the oldest. The result sits in an output register; the next item is
// accepted while it waits, and a new result is held back only while the old
// one is stalled. Reset empties the list, drops valid output and marks the
// cache not ready, so the first lookup clears it. Config writes go through
// the APB port and take effect at the next clear, the tile base also at each
// result; write them only while the block is idle.
// ----------------------------------------------------------------------------
module lru_glyph_tile_cache (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lgtc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lgtc_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    lgtc_pkg::t_cfg r_cfg;
    lgtc_pkg::t_cmd cmd;
    lgtc_pkg::t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                lgtc_pkg::REG_TILE_BASE: r_cfg.tile_base      <= pwdata[7:0];
                lgtc_pkg::REG_LAST_TILE: r_cfg.last_tile      <= pwdata[7:0];
                lgtc_pkg::REG_PLACEMENT: r_cfg.placement      <= pwdata[1:0];
                lgtc_pkg::REG_COLOR_HW:  r_cfg.color_hardware <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lgtc_pkg::REG_TILE_BASE: prdata = {24'd0, r_cfg.tile_base};
            lgtc_pkg::REG_LAST_TILE: prdata = {24'd0, r_cfg.last_tile};
            lgtc_pkg::REG_PLACEMENT: prdata = {30'd0, r_cfg.placement};
            lgtc_pkg::REG_COLOR_HW:  prdata = {31'd0, r_cfg.color_hardware};
            default:                 prdata = '0;
        endcase
    end

    lgtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lgtc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .i_item      (i_in_item),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
